// ===== design/mbd_pkg.sv =====
package mbd_pkg;

  // Fixed field widths
  localparam int LANES     = 4;
  localparam int BYTE_W    = 8;
  localparam int SUM_W     = BYTE_W + 1;
  localparam int LINE_W    = LANES * SUM_W;
  localparam int DIM_W     = 13;
  localparam int CHAN_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_HEIGHT = 4096;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF    = 4096;
  localparam int MAX_CHANNELS_DEF = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_COUNT = 2'd2;

  // Reset values of the registers
  localparam logic [DIM_W-1:0]  SRC_WIDTH_RST  = 13'd1;
  localparam logic [DIM_W-1:0]  SRC_HEIGHT_RST = 13'd1;
  localparam logic [CHAN_W-1:0] CHAN_COUNT_RST = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] chan_d_in;
    logic [BYTE_W-1:0] chan_c_in;
    logic [BYTE_W-1:0] chan_b_in;
    logic [BYTE_W-1:0] chan_a_in;
  } in_item_t;

  typedef struct packed {
    logic              image_last;
    logic [BYTE_W-1:0] chan_d_out;
    logic [BYTE_W-1:0] chan_c_out;
    logic [BYTE_W-1:0] chan_b_out;
    logic [BYTE_W-1:0] chan_a_out;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DIM_W-1:0]     reg_value;
  } cfg_item_t;

  // Per-request decision from the position counters
  typedef struct packed {
    logic emit;     // request completes an output texel
    logic last;     // that texel closes the mip level
    logic quad;     // 2x2 average, else pair average
    logic line_wr;  // store the pair sum in the line store
    logic line_rd;  // fetch the pair sum of the row above
  } ctrl_t;

endpackage

// ===== design/mbd_stream_if.sv =====
interface mbd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mbd_line_store.sv =====
module mbd_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [mbd_pkg::LINE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [mbd_pkg::LINE_W-1:0] rd_data
);

  logic [mbd_pkg::LINE_W-1:0] mem [DEPTH];
  logic [mbd_pkg::LINE_W-1:0] rd_data_r;

  // Write the even-row pair sums
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read on request only, so the data holds while the pipe stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/mbd_lane.sv =====
module mbd_lane (
  input  logic                      clk,
  input  logic                      load,
  input  logic [mbd_pkg::BYTE_W-1:0] held_byte,
  input  logic [mbd_pkg::BYTE_W-1:0] cur_byte,
  input  logic                      quad,
  input  logic [mbd_pkg::SUM_W-1:0]  line_sum,
  output logic [mbd_pkg::SUM_W-1:0]  pair_sum,
  output logic [mbd_pkg::BYTE_W-1:0] result
);

  logic [mbd_pkg::SUM_W-1:0]   sum_r;
  logic [mbd_pkg::SUM_W:0]     quad_sum;

  // Horizontal pair sum of the held and current byte
  assign pair_sum = {1'b0, held_byte} + {1'b0, cur_byte};

  // Hold the pair sum for the result stage
  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= pair_sum;
    end
  end

  // Add the row above and scale
  assign quad_sum = {1'b0, sum_r} + {1'b0, line_sum};

  always_comb begin
    if (quad) begin
      result = quad_sum[mbd_pkg::SUM_W:2];
    end else begin
      result = sum_r[mbd_pkg::SUM_W-1:1];
    end
  end

endmodule

// ===== design/mbd_ctrl.sv =====
module mbd_ctrl #(
  parameter int MAX_WIDTH = 4096,
  parameter int AW        = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [mbd_pkg::DIM_W-1:0] src_width,
  input  logic [mbd_pkg::DIM_W-1:0] src_height,
  output mbd_pkg::ctrl_t            ctrl,
  output logic [AW-1:0]             line_addr
);

  localparam int DW = mbd_pkg::DIM_W;
  localparam logic [DW+1:0] MaxW = (DW + 2)'(MAX_WIDTH);
  localparam logic [DW-1:0] MaxH = DW'(mbd_pkg::MAX_HEIGHT);

  logic [DW-1:0] col_r, col_nxt;
  logic [DW-1:0] row_r, row_nxt;
  logic [DW-1:0] w, h, w2, h2;
  logic [DW-1:0] half_col;
  logic [DW:0]   col_inc, row_inc;
  logic [DW:0]   pos_sum, pair_lim;
  logic          quad, block_hit, pair_hit, single;

  // Clamp the dimensions
  always_comb begin
    if (src_width == '0) begin
      w = DW'(1);
    end else if ({2'b00, src_width} > MaxW) begin
      w = MaxW[DW-1:0];
    end else begin
      w = src_width;
    end
    if (src_height == '0) begin
      h = DW'(1);
    end else if (src_height > MaxH) begin
      h = MaxH;
    end else begin
      h = src_height;
    end
  end

  assign w2     = {w[DW-1:1], 1'b0};
  assign h2     = {h[DW-1:1], 1'b0};
  assign quad   = (w[DW-1:1] != '0) && (h[DW-1:1] != '0);
  assign single = (w == DW'(1)) && (h == DW'(1));

  // 2x2 block position test
  assign block_hit = col_r[0] && (col_r < w2) && (row_r < h2);

  // Single row or column: pair texels in stream order
  assign pos_sum  = {1'b0, col_r} + {1'b0, row_r};
  assign pair_lim = {1'b0, w2} + {1'b0, h2};
  assign pair_hit = !quad && !single && pos_sum[0] && (pos_sum < pair_lim);

  always_comb begin
    ctrl.quad    = quad;
    ctrl.line_wr = quad && block_hit && !row_r[0];
    ctrl.line_rd = quad && block_hit && row_r[0];
    if (quad) begin
      ctrl.emit = block_hit && row_r[0];
      ctrl.last = (row_r == h2 - DW'(1)) && (col_r == w2 - DW'(1));
    end else begin
      ctrl.emit = pair_hit;
      ctrl.last = (pos_sum == pair_lim - (DW + 1)'(1));
    end
  end

  assign half_col  = col_r >> 1;
  assign line_addr = half_col[AW-1:0];

  // Advance the raster position, wrapping at row and image end
  assign col_inc = {1'b0, col_r} + (DW + 1)'(1);
  assign row_inc = {1'b0, row_r} + (DW + 1)'(1);

  always_comb begin
    col_nxt = col_inc[DW-1:0];
    row_nxt = row_r;
    if (col_inc >= {1'b0, w}) begin
      col_nxt = '0;
      if (row_inc >= {1'b0, h}) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== design/mipmap_box_downsample.sv =====
// 2x2 box-filter mip level generator (pair average for a single row or column).
// in_s takes source texels in raster order, four channel bytes each, as
// valid/ready requests; out_s gives the averaged texels of the next level,
// with image_last on the final one. cfg_s writes source_width (index 0),
// source_height (index 1) and channel_count (index 2); it is always ready.
// It is to be written only between images; the block itself does not enforce it.
// Throughput: one texel per clock on in_s while out_s keeps up. A result
// passes from the lane stage to the result register before it is valid on
// out_s. The line store is one write port and one registered read
// port; the pair sums of an even row are written there and read back one
// row later, and one read of the row above per output keeps the rate at
// one per clock.
// The position counters wrap after every full image.
// Reset (rst_n low, synchronous) empties the pipe, clears the counters and
// the held texel and returns the registers to width 1, height 1 and four
// channels. The line store has no reset; each entry is written on an even
// row before it is read.
// When out_s stalls, the result register holds and one more completed
// texel waits in the lane stage; in_s then drops ready until out_s moves.
module mipmap_box_downsample #(
  parameter int MAX_WIDTH    = mbd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CHANNELS = mbd_pkg::MAX_CHANNELS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  mbd_stream_if.sink   in_s,
  mbd_stream_if.source out_s,
  mbd_stream_if.sink   cfg_s
);

  localparam int LineDepth = (MAX_WIDTH + 1) / 2;
  localparam int AW        = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int BW        = mbd_pkg::BYTE_W;
  localparam int SW        = mbd_pkg::SUM_W;

  logic [mbd_pkg::DIM_W-1:0]  src_width_r, src_height_r;
  logic [mbd_pkg::CHAN_W-1:0] chan_count_r;
  logic [mbd_pkg::LANES*BW-1:0] held_r, cur_texel;
  logic [mbd_pkg::LINE_W-1:0] fresh_line, line_rd_data;
  logic [AW-1:0]              line_addr;
  logic [BW-1:0]              res [mbd_pkg::LANES];
  logic [mbd_pkg::LANES-1:0]  lane_en;
  mbd_pkg::ctrl_t             ctrl;
  mbd_pkg::in_item_t          in_item;
  mbd_pkg::cfg_item_t         cfg_item;
  mbd_pkg::out_item_t         out_data_r;
  logic s1_valid_r, s1_last_r, s1_quad_r;
  logic out_valid_r;
  logic in_acc, s1_move, s1_load;

  // Configuration registers
  assign cfg_s.ready = 1'b1;
  assign cfg_item    = cfg_s.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= mbd_pkg::SRC_WIDTH_RST;
      src_height_r <= mbd_pkg::SRC_HEIGHT_RST;
      chan_count_r <= mbd_pkg::CHAN_COUNT_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_item.reg_index)
        mbd_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_item.reg_value;
        mbd_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_item.reg_value;
        mbd_pkg::REG_CHAN_COUNT: chan_count_r <= cfg_item.reg_value[mbd_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the lane stage frees when the result register can take it
  assign s1_move    = s1_valid_r && (!out_valid_r || out_s.ready);
  assign in_s.ready = !s1_valid_r || s1_move;
  assign in_acc     = in_s.valid && in_s.ready;
  assign s1_load    = in_acc && ctrl.emit;

  assign in_item   = in_s.data;
  assign cur_texel = {in_item.chan_d_in, in_item.chan_c_in,
                      in_item.chan_b_in, in_item.chan_a_in};

  mbd_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (in_acc),
    .src_width  (src_width_r),
    .src_height (src_height_r),
    .ctrl       (ctrl),
    .line_addr  (line_addr)
  );

  // Hold the previous texel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (in_acc) begin
      held_r <= cur_texel;
    end
  end

  mbd_line_store #(
    .DEPTH (LineDepth),
    .AW    (AW)
  ) u_line (
    .clk     (clk),
    .wr_en   (in_acc && ctrl.line_wr),
    .wr_addr (line_addr),
    .wr_data (fresh_line),
    .rd_en   (in_acc && ctrl.line_rd),
    .rd_addr (line_addr),
    .rd_data (line_rd_data)
  );

  // One lane per channel byte
  for (genvar i = 0; i < mbd_pkg::LANES; i++) begin : g_lane
    mbd_lane u_lane (
      .clk       (clk),
      .load      (s1_load),
      .held_byte (held_r[BW*i +: BW]),
      .cur_byte  (cur_texel[BW*i +: BW]),
      .quad      (s1_quad_r),
      .line_sum  (line_rd_data[SW*i +: SW]),
      .pair_sum  (fresh_line[SW*i +: SW]),
      .result    (res[i])
    );
    assign lane_en[i] = (mbd_pkg::CHAN_W'(i) < chan_count_r) && (i < MAX_CHANNELS);
  end

  // Lane stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= ctrl.emit;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_last_r <= ctrl.last;
      s1_quad_r <= ctrl.quad;
    end
  end

  // Merge the lanes into the result register, zeroing unused lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.chan_a_out <= lane_en[0] ? res[0] : '0;
      out_data_r.chan_b_out <= lane_en[1] ? res[1] : '0;
      out_data_r.chan_c_out <= lane_en[2] ? res[2] : '0;
      out_data_r.chan_d_out <= lane_en[3] ? res[3] : '0;
      out_data_r.image_last <= s1_last_r;
    end
  end

  assign out_s.valid = out_valid_r;
  assign out_s.data  = out_data_r;

endmodule

// ===== tb/sv/mip_level_checker.sv =====
`timescale 1ns / 1ps

module mip_level_checker
  import mbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_item_t cfg_data,
  output int        mismatches,
  output int        pending
);

  localparam int MAX_W      = MAX_WIDTH_DEF;
  localparam int LINE_DEPTH = (MAX_W + 1) / 2;

  // Shadow registers and position state of the mip generator
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [CHAN_W-1:0] lanes_reg;
  logic [LINE_W-1:0] pair_sums [LINE_DEPTH];
  logic [31:0]       prev_texel;
  int unsigned       col;
  int unsigned       row;

  out_item_t awaited_texels[$];
  int        texels_seen;

  task automatic report_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
    $display("%0t: output texel %0d, %s: expected %0h, got %0h",
             $time, texels_seen, what, want, got);
    mismatches++;
  endtask

  // Work out the texel, if any, that one source texel completes
  task automatic predict_mip_texel(input in_item_t px);
    int unsigned       w, h, dw, dh, idx, p, n, used;
    logic [31:0]       cur;
    logic [31:0]       avg;
    logic [LINE_W-1:0] fresh;
    logic [LINE_W-1:0] above;
    logic [8:0]        s;
    logic [9:0]        t;
    logic              emit;
    logic              last;
    cur  = px;
    avg  = '0;
    emit = 1'b0;
    last = 1'b0;
    w    = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h    = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    dw   = w >> 1;
    dh   = h >> 1;
    used = (lanes_reg > LANES) ? LANES : lanes_reg;

    if (dw != 0 && dh != 0) begin
      // 2x2 blocks: even rows park pair sums, odd rows finish the block
      if (col[0] && col < 2 * dw && row < 2 * dh) begin
        idx   = col >> 1;
        above = pair_sums[idx];
        fresh = '0;
        for (int i = 0; i < LANES; i++) begin
          s = {1'b0, prev_texel[8*i +: 8]} + {1'b0, cur[8*i +: 8]};
          if (!row[0]) begin
            fresh[SUM_W*i +: SUM_W] = s;
          end else begin
            t = {1'b0, s} + {1'b0, above[SUM_W*i +: SUM_W]};
            avg[8*i +: 8] = t[9:2];
          end
        end
        if (!row[0]) begin
          pair_sums[idx] = fresh;
        end else begin
          emit = 1'b1;
          last = (row == 2 * dh - 1) && (col == 2 * dw - 1);
        end
      end
    end else if (w != 1 || h != 1) begin
      // single row or column: average consecutive pairs in stream order
      p = col + row;
      n = dw + dh;
      if (p[0] && p < 2 * n) begin
        for (int i = 0; i < LANES; i++) begin
          s = {1'b0, prev_texel[8*i +: 8]} + {1'b0, cur[8*i +: 8]};
          avg[8*i +: 8] = s[8:1];
        end
        emit = 1'b1;
        last = (p == 2 * n - 1);
      end
    end

    prev_texel = cur;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end

    if (emit) begin
      // zero the lanes beyond the channel count
      for (int i = 0; i < LANES; i++)
        if (i >= used) avg[8*i +: 8] = '0;
      awaited_texels.push_back(out_item_t'({last, avg}));
    end
  endtask

  task automatic check_texel(input out_item_t got);
    out_item_t want;
    if (awaited_texels.size() == 0) begin
      report_mismatch("texel with none awaited", '0, 40'(got));
    end else begin
      want = awaited_texels.pop_front();
      if (got.chan_a_out !== want.chan_a_out)
        report_mismatch("chan_a_out", 40'(want.chan_a_out), 40'(got.chan_a_out));
      if (got.chan_b_out !== want.chan_b_out)
        report_mismatch("chan_b_out", 40'(want.chan_b_out), 40'(got.chan_b_out));
      if (got.chan_c_out !== want.chan_c_out)
        report_mismatch("chan_c_out", 40'(want.chan_c_out), 40'(got.chan_c_out));
      if (got.chan_d_out !== want.chan_d_out)
        report_mismatch("chan_d_out", 40'(want.chan_d_out), 40'(got.chan_d_out));
      if (got.image_last !== want.image_last)
        report_mismatch("image_last", 40'(want.image_last), 40'(got.image_last));
    end
  endtask

  // Snoop the three channels at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg   = SRC_WIDTH_RST;
      height_reg  = SRC_HEIGHT_RST;
      lanes_reg   = CHAN_COUNT_RST;
      prev_texel  = '0;
      col         = 0;
      row         = 0;
      mismatches  = 0;
      texels_seen = 0;
      awaited_texels.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_texel(out_data);
        texels_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.reg_index)
          REG_SRC_WIDTH:  width_reg  = cfg_data.reg_value;
          REG_SRC_HEIGHT: height_reg = cfg_data.reg_value;
          REG_CHAN_COUNT: lanes_reg  = cfg_data.reg_value[CHAN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_mip_texel(in_data);
    end
    pending = awaited_texels.size();
  end

endmodule

// ===== tb/sv/mipmap_box_downsample_test.sv =====
`timescale 1ns / 1ps

module mipmap_box_downsample_test;
  import mbd_pkg::*;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_TEXELS = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;

  typedef enum int { FILL_RANDOM, FILL_WHITE, FILL_STRIPES } fill_e;
  typedef enum int { FLOW_FREE, FLOW_RANDOM, FLOW_PERIODIC } flow_e;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;
  bit   squeeze_req;
  int   burst_left;
  int   texels_sent;
  int   drain_wait;

  mbd_stream_if #(.payload_t(in_item_t))  in_if ();
  mbd_stream_if #(.payload_t(out_item_t)) out_if ();
  mbd_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

  mipmap_box_downsample dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if),
    .cfg_s (cfg_if)
  );

  mip_level_checker watch (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_data    (in_if.data),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_data   (out_if.data),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_data   (cfg_if.data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_item_t make_texel(input fill_e fill, input int k);
    case (fill)
      FILL_WHITE:   return '1;
      FILL_STRIPES: return k[0] ? '1 : '0;
      default:      return in_item_t'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] random_dim();
    return ($urandom_range(0, 11) == 0) ? '0 : DIM_W'($urandom_range(1, 12));
  endfunction

  // Offer one texel in the current burst; open a gap when the burst runs out
  task automatic push_texel(input in_item_t px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= px;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    texels_sent++;
  endtask

  // Leave valid high across back-to-back writes; the caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_index: idx, reg_value: val};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain every awaited texel, then let the pipe empty of silent requests
  task automatic settle_pipe();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_image(input logic [DIM_W-1:0] wr, input logic [DIM_W-1:0] hr,
                           input logic [CHAN_W-1:0] cc, input fill_e fill,
                           input bit squeeze);
    int unsigned      we;
    int unsigned      he;
    logic [DIM_W-1:0] cval;
    settle_pipe();
    // upper bits of the channel count write are don't-care: scramble them
    cval = DIM_W'($urandom);
    cval[CHAN_W-1:0] = cc;
    write_reg(REG_SRC_WIDTH, wr);
    write_reg(REG_SRC_HEIGHT, hr);
    write_reg(REG_CHAN_COUNT, cval);
    cfg_if.valid <= 1'b0;
    if (squeeze) squeeze_req = 1'b1;
    we = (wr == 0) ? 1 : ((wr > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wr);
    he = (hr == 0) ? 1 : ((hr > MAX_HEIGHT) ? MAX_HEIGHT : hr);
    for (int k = 0; k < we * he; k++) push_texel(make_texel(fill, k));
  endtask

  // Result side: stall patterns, plus one long hold-off on request
  initial begin
    flow_e mode;
    int    span;
    int    phase_len;
    bit    squeeze_done;
    squeeze_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        repeat (SQUEEZE_CYCLES) begin
          @(negedge clk);
          out_if.ready <= 1'b0;
        end
        squeeze_done = 1'b1;
      end else begin
        mode      = flow_e'($urandom_range(0, 2));
        span      = $urandom_range(10, 150);
        phase_len = $urandom_range(1, 4);
        for (int c = 0; c < span; c++) begin
          // start the hold-off as soon as it is asked for
          if (squeeze_req && !squeeze_done) break;
          @(negedge clk);
          case (mode)
            FLOW_FREE:   out_if.ready <= 1'b1;
            FLOW_RANDOM: out_if.ready <= ($urandom_range(0, 2) != 0);
            default:     out_if.ready <= ((c / phase_len) % 2 == 0);
          endcase
        end
      end
    end
  end

  initial begin
    #16_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    squeeze_req  = 1'b0;
    burst_left   = 0;
    texels_sent  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers give a 1x1 image: texels produce nothing
    push_texel(make_texel(FILL_WHITE, 0));
    push_texel(make_texel(FILL_RANDOM, 1));
    // full-scale bytes through a single 2x2 block
    run_image(13'd2, 13'd2, 3'd4, FILL_WHITE, 1'b0);
    // odd sizes drop the last column and row; counts above four use all lanes
    run_image(13'd3, 13'd3, 3'd7, FILL_STRIPES, 1'b0);
    // zero width means one column; zero channels blanks every lane
    run_image(13'd0, 13'd4, 3'd0, FILL_RANDOM, 1'b0);
    // single row with a trailing odd texel, one lane in use
    run_image(13'd5, 13'd1, 3'd1, FILL_STRIPES, 1'b0);

    // random small images, now and then a write to the unused index
    texels_sent = 0;
    while (texels_sent < RANDOM_TEXELS) begin
      if ($urandom_range(0, 15) == 0) begin
        settle_pipe();
        write_reg(REG_SPARE, DIM_W'($urandom));
        cfg_if.valid <= 1'b0;
      end
      run_image(random_dim(), random_dim(), CHAN_W'($urandom_range(0, 7)),
                ($urandom_range(0, 7) == 0) ? fill_e'($urandom_range(1, 2)) : FILL_RANDOM,
                1'b0);
    end

    // long hold-off on the result side while texels keep coming
    run_image(13'd9, 13'd8, 3'd4, FILL_RANDOM, 1'b1);

    // wait for the last texels, bounded
    in_if.valid <= 1'b0;
    drain_wait = 0;
    while (pending != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending != 0) $display("%0d output texels never arrived", pending);

    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
